// ===== rtl/dlf_pkg.sv =====
// shared types, codes and exp tables for the dense layer unit
// no dependencies
`default_nettype none
package dlf_pkg;

  localparam int MAX_IN_DEF  = 64;
  localparam int MAX_OUT_DEF = 64;

  // request codes
  localparam logic [2:0] REQ_WR_W   = 3'd0;
  localparam logic [2:0] REQ_WR_B   = 3'd1;
  localparam logic [2:0] REQ_X      = 3'd2;
  localparam logic [2:0] REQ_STEP_W = 3'd3;
  localparam logic [2:0] REQ_STEP_B = 3'd4;

  // activation codes
  localparam logic [1:0] ACT_RELU    = 2'd0;
  localparam logic [1:0] ACT_SOFTMAX = 2'd1;
  localparam logic [1:0] ACT_SIGMOID = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ACT_MODE   = 2'd0;
  localparam logic [1:0] CFG_IN_COUNT   = 2'd1;
  localparam logic [1:0] CFG_OUT_COUNT  = 2'd2;
  localparam logic [1:0] CFG_LEARN_RATE = 2'd3;

  localparam logic [1:0]  ACT_MODE_RST   = ACT_RELU;
  localparam logic [6:0]  IN_COUNT_RST   = 7'd64;
  localparam logic [6:0]  OUT_COUNT_RST  = 7'd64;
  localparam logic [15:0] LEARN_RATE_RST = 16'd655;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] data_value;
    logic               last_elem;
  } in_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [15:0] out_value;
    logic               out_last;
  } out_t;

  typedef struct packed {
    logic [1:0]  act_mode;
    logic [6:0]  in_count;
    logic [6:0]  out_count;
    logic [15:0] learn_rate;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    logic [2:0]         op;
    logic               wr_ok;
    logic               start;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] data;
  } cmd_t;

  // exp(-n) for integer n, Q1.16
  function automatic logic [16:0] exp_int_lut(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-k/16), Q1.16
  function automatic logic [16:0] exp_frac_lut(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dlf_front.sv =====
// front end: accepts input transactions, classifies them, two-entry queue
// depends on dlf_pkg
`default_nettype none
module dlf_front import dlf_pkg::*; #(
  parameter int MAX_IN  = MAX_IN_DEF,
  parameter int MAX_OUT = MAX_OUT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      cmd_valid,
  input  wire logic cmd_pop,
  output cmd_t      cmd
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       keep, row_ok, col_ok, push, pop;

  always_comb begin
    row_ok    = ({1'b0, in_data.row_index} < 7'(MAX_IN));
    col_ok    = ({1'b0, in_data.col_index} < 7'(MAX_OUT));
    cls.op    = in_data.req_type;
    cls.row   = in_data.row_index;
    cls.col   = in_data.col_index;
    cls.data  = in_data.data_value;
    cls.start = 1'b0;
    cls.wr_ok = 1'b0;
    keep      = 1'b1;
    unique case (in_data.req_type)
      REQ_WR_W, REQ_STEP_W: cls.wr_ok = row_ok && col_ok;
      REQ_WR_B, REQ_STEP_B: cls.wr_ok = col_ok;
      REQ_X: begin
        cls.wr_ok = row_ok;
        cls.start = in_data.last_elem;
      end
      default: keep = 1'b0;
    endcase
    // nothing to do for out-of-range writes unless they start a pass
    if (!cls.wr_ok && !cls.start) keep = 1'b0;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && !in_stall && keep;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dlf_exp.sv =====
// pipelined exp(-a) for a in Q8.8, result Q1.16
// depends on dlf_pkg
`default_nettype none
module dlf_exp import dlf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] a,
  output logic             done,
  output logic [16:0]      e
);

  logic [33:0] p1_r, p2_r;
  logic [3:0]  r1_r;
  logic        z1_r, z2_r, v1_r, v2_r, v3_r;
  logic [16:0] e_r;
  logic [33:0] s1, s2;
  logic [16:0] e1, f2;

  always_comb begin
    s1 = p1_r + 34'd32768;
    e1 = s1[32:16];
    f2 = 17'd65536 - {5'd0, r1_r, 8'd0};
    s2 = p2_r + 34'd32768;
  end

  always_ff @(posedge clk) begin
    p1_r <= {17'd0, exp_int_lut(a[11:8])} * {17'd0, exp_frac_lut(a[7:4])};
    r1_r <= a[3:0];
    z1_r <= (a[15:8] > 8'd11);
    p2_r <= {17'd0, e1} * {17'd0, f2};
    z2_r <= z1_r;
    e_r  <= z2_r ? 17'd0 : s2[32:16];
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done = v3_r;
  assign e    = e_r;

endmodule
`default_nettype wire

// ===== rtl/dlf_div.sv =====
// restoring divider, one quotient bit per cycle, quotient below 512
// no dependencies beyond dlf_pkg
`default_nettype none
module dlf_div import dlf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [24:0] num,
  input  wire logic [22:0] den,
  output logic             done,
  output logic [8:0]       q
);

  logic [24:0] rem_r;
  logic [22:0] den_r;
  logic [8:0]  q_r;
  logic [3:0]  k_r;
  logic        busy_r, done_r;
  logic [31:0] dsh, rem_w;

  always_comb begin
    dsh   = {9'd0, den_r} << k_r;
    rem_w = {7'd0, rem_r};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= 9'd0;
      k_r   <= 4'd8;
    end else if (busy_r) begin
      if (rem_w >= dsh) begin
        rem_r    <= 25'(rem_w - dsh);
        q_r[k_r] <= 1'b1;
      end
      k_r <= k_r - 4'd1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (k_r == 4'd0);
      if (start) busy_r <= 1'b1;
      else if (k_r == 4'd0) busy_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
`default_nettype wire

// ===== rtl/dlf_exec.sv =====
// back end: stores, gradient steps, multiply-accumulate and activation sequencer
// depends on dlf_pkg, dlf_exp, dlf_div
`default_nettype none
module dlf_exec import dlf_pkg::*; #(
  parameter int MAX_IN  = MAX_IN_DEF,
  parameter int MAX_OUT = MAX_OUT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int IW  = (MAX_IN  > 1) ? $clog2(MAX_IN)  : 1;
  localparam int OW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WAW = IW + OW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_STEP_RD  = 4'd1;
  localparam logic [3:0] S_STEP_MUL = 4'd2;
  localparam logic [3:0] S_STEP_WR  = 4'd3;
  localparam logic [3:0] S_ROW      = 4'd4;
  localparam logic [3:0] S_MAC      = 4'd5;
  localparam logic [3:0] S_DRAIN    = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;
  localparam logic [3:0] S_SREAD    = 4'd8;
  localparam logic [3:0] S_SZ       = 4'd9;
  localparam logic [3:0] S_SEXP     = 4'd10;
  localparam logic [3:0] S_OREAD    = 4'd11;
  localparam logic [3:0] S_OZ       = 4'd12;
  localparam logic [3:0] S_OEXP     = 4'd13;
  localparam logic [3:0] S_ODIV     = 4'd14;
  localparam logic [3:0] S_EMIT     = 4'd15;

  // stores
  logic [15:0] w_mem [2**WAW];
  logic [15:0] b_mem [2**OW];
  logic [15:0] x_mem [2**IW];
  logic [15:0] z_mem [2**OW];
  logic [15:0] w_q_r, b_q_r, x_q_r, z_q_r;

  logic [3:0]  state_r, state_nxt;
  cmd_t        cur_r;
  logic [6:0]  i_r, i_nxt, j_r, j_nxt, ni, no;
  logic        mac_first_r;
  logic        rdv_r, mulv_r;
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [15:0] m_r, old_r, res_r, res_nxt;
  logic signed [32:0] sprod_r;
  logic [22:0] sum_r;
  logic [16:0] ex_r;
  out_t        out_r;
  logic        out_valid_r, out_free;
  // divider launch in the cycle in which the exp result first sits in ex_r
  logic        div_go_r;

  logic            w_we, b_we, x_we, z_we;
  logic [WAW-1:0]  w_waddr, w_raddr;
  logic [OW-1:0]   b_waddr, b_raddr;
  logic [IW-1:0]   x_waddr;
  logic [15:0]     w_wdata, b_wdata;
  logic signed [15:0] zval, step_new;
  logic signed [39:0] accp;
  logic signed [33:0] sp;
  logic signed [18:0] sdiff;
  logic signed [16:0] zneg, mdiff;

  logic        exp_start, exp_done, div_start, div_done;
  logic [15:0] exp_a;
  logic [16:0] exp_e;
  logic [24:0] div_num;
  logic [22:0] div_den;
  logic [8:0]  div_q;
  logic [17:0] sig_den;

  dlf_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .a     (exp_a),
    .done  (exp_done),
    .e     (exp_e)
  );

  dlf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    ni = (cfg.in_count == 7'd0) ? 7'd1 :
         (cfg.in_count > 7'(MAX_IN)) ? 7'(MAX_IN) : cfg.in_count;
    no = (cfg.out_count == 7'd0) ? 7'd1 :
         (cfg.out_count > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cfg.out_count;
    out_free = !out_valid_r || !out_stall;

    // output rounding and saturation of the accumulator
    accp = acc_r + 40'sd128;
    if ((accp >>> 8) > 40'sd32767)       zval = 16'sh7fff;
    else if ((accp >>> 8) < -40'sd32768) zval = -16'sh8000;
    else                                 zval = 16'(accp >>> 8);

    // gradient step
    sp    = 34'(sprod_r) + 34'sd32768;
    sdiff = 19'(old_r) - 19'(sp >>> 16);
    if (sdiff > 19'sd32767)       step_new = 16'sh7fff;
    else if (sdiff < -19'sd32768) step_new = -16'sh8000;
    else                          step_new = 16'(sdiff);

    zneg  = -17'(signed'(z_q_r));
    mdiff = 17'(m_r) - 17'(signed'(z_q_r));
    sig_den = 18'd65536 + 18'(ex_r);

    w_raddr = (state_r == S_MAC) ? {i_r[IW-1:0], j_r[OW-1:0]}
                                 : {cur_r.row[IW-1:0], cur_r.col[OW-1:0]};
    b_raddr = (state_r == S_ROW) ? j_r[OW-1:0] : cur_r.col[OW-1:0];

    w_we = 1'b0; b_we = 1'b0; x_we = 1'b0; z_we = 1'b0;
    w_waddr = {cmd.row[IW-1:0], cmd.col[OW-1:0]};
    b_waddr = cmd.col[OW-1:0];
    x_waddr = cmd.row[IW-1:0];
    w_wdata = cmd.data;
    b_wdata = cmd.data;

    cmd_pop   = 1'b0;
    exp_start = 1'b0;
    exp_a     = mdiff[15:0];
    div_start = div_go_r;
    div_num   = 25'(ex_r) * 25'd256 + 25'(sum_r >> 1);
    div_den   = sum_r;
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    res_nxt   = res_r;

    unique case (state_r)
      S_IDLE: begin
        cmd_pop = 1'b1;
        if (cmd_valid) begin
          case (cmd.op)
            REQ_WR_W: w_we = cmd.wr_ok;
            REQ_WR_B: b_we = cmd.wr_ok;
            REQ_X: begin
              x_we = cmd.wr_ok;
              if (cmd.start) begin
                state_nxt = S_ROW;
                j_nxt     = 7'd0;
              end
            end
            default: if (cmd.wr_ok) state_nxt = S_STEP_RD;
          endcase
        end
      end
      S_STEP_RD:  state_nxt = S_STEP_MUL;
      S_STEP_MUL: state_nxt = S_STEP_WR;
      S_STEP_WR: begin
        w_waddr = {cur_r.row[IW-1:0], cur_r.col[OW-1:0]};
        b_waddr = cur_r.col[OW-1:0];
        w_wdata = step_new;
        b_wdata = step_new;
        if (cur_r.op == REQ_STEP_W) w_we = 1'b1;
        else                        b_we = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROW: begin
        i_nxt     = 7'd0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        if (i_r == ni - 7'd1) state_nxt = S_DRAIN;
        else                  i_nxt = i_r + 7'd1;
      end
      S_DRAIN: if (!rdv_r && !mulv_r) state_nxt = S_FIN;
      S_FIN: begin
        z_we = 1'b1;
        if (j_r == no - 7'd1) begin
          j_nxt     = 7'd0;
          state_nxt = (cfg.act_mode == ACT_SOFTMAX) ? S_SREAD : S_OREAD;
        end else begin
          j_nxt     = j_r + 7'd1;
          state_nxt = S_ROW;
        end
      end
      S_SREAD: state_nxt = S_SZ;
      S_SZ: begin
        exp_start = 1'b1;
        state_nxt = S_SEXP;
      end
      S_SEXP: begin
        if (exp_done) begin
          if (j_r == no - 7'd1) begin
            j_nxt     = 7'd0;
            state_nxt = S_OREAD;
          end else begin
            j_nxt     = j_r + 7'd1;
            state_nxt = S_SREAD;
          end
        end
      end
      S_OREAD: state_nxt = S_OZ;
      S_OZ: begin
        unique case (cfg.act_mode)
          ACT_RELU: begin
            res_nxt   = z_q_r[15] ? 16'sd0 : z_q_r;
            state_nxt = S_EMIT;
          end
          ACT_SOFTMAX: begin
            exp_start = 1'b1;
            state_nxt = S_OEXP;
          end
          ACT_SIGMOID: begin
            exp_a     = z_q_r[15] ? zneg[15:0] : z_q_r;
            exp_start = 1'b1;
            state_nxt = S_OEXP;
          end
          ACT_NONE: begin
            res_nxt   = z_q_r;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_OEXP: if (exp_done) state_nxt = S_ODIV;
      S_ODIV: begin
        // divider starts on entry, ex_r already holds the exp value
        if (cfg.act_mode == ACT_SIGMOID) begin
          div_den = 23'(sig_den);
          div_num = z_q_r[15] ? 25'(ex_r) * 25'd256 + 25'(sig_den >> 1)
                              : 25'd16777216 + 25'(sig_den >> 1);
        end
        if (div_done) begin
          res_nxt   = 16'(div_q);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (j_r == no - 7'd1) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 7'd1;
            state_nxt = S_OREAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    if (b_we) b_mem[b_waddr] <= b_wdata;
    if (x_we) x_mem[x_waddr] <= cmd.data;
    if (z_we) z_mem[j_r[OW-1:0]] <= zval;
    w_q_r <= w_mem[w_raddr];
    b_q_r <= b_mem[b_raddr];
    x_q_r <= x_mem[i_r[IW-1:0]];
    z_q_r <= z_mem[j_r[OW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid) cur_r <= cmd;
    if (state_r == S_STEP_MUL) begin
      old_r   <= (cur_r.op == REQ_STEP_W) ? w_q_r : b_q_r;
      sprod_r <= signed'({17'd0, cfg.learn_rate}) * 33'(cur_r.data);
    end
    prod_r <= signed'(w_q_r) * signed'(x_q_r);
    if (state_r == S_MAC && mac_first_r)
      acc_r <= {{16{b_q_r[15]}}, b_q_r, 8'd0};
    else if (mulv_r)
      acc_r <= acc_r + 40'(prod_r);
    if (state_r == S_FIN && (j_r == 7'd0 || zval > m_r)) m_r <= zval;
    if (state_r == S_FIN) sum_r <= 23'd0;
    if (state_r == S_SEXP && exp_done) sum_r <= sum_r + 23'(exp_e);
    if (exp_done) ex_r <= exp_e;
    res_r <= res_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_r.out_index <= j_r[5:0];
      out_r.out_value <= res_r;
      out_r.out_last  <= (j_r == no - 7'd1);
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= 7'd0;
      j_r         <= 7'd0;
      mac_first_r <= 1'b0;
      rdv_r       <= 1'b0;
      mulv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      mac_first_r <= (state_r == S_ROW);
      rdv_r       <= (state_r == S_MAC);
      mulv_r      <= rdv_r;
      div_go_r    <= (state_r == S_OEXP) && exp_done;
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/dense_layer_forward_sgd_unit.sv =====
// top level of the dense layer unit: configuration registers, front and back
// depends on dlf_pkg, dlf_front, dlf_exec
`default_nettype none
// Fully connected layer z_j = bias_j + sum_i w_ij * x_i in signed Q8.8 with
// relu, softmax or sigmoid on the way out (act_mode 3 passes z unchanged).
// Input transactions write a weight, a bias or one x element, or take a
// gradient step on one weight or bias; an x element with last_elem set
// starts a pass that emits out_count result transactions (out_count clamped
// to 1..MAX_OUT) in order of j, out_last marking the final one. A gradient
// step reads the old value, multiplies and writes back in the back end. A
// pass runs each output through the single shared multiply-accumulate,
// then through relu directly, or through the exp pipeline and a nine-step
// divider for sigmoid and softmax; softmax adds a sum pass over the outputs.
// A two-entry queue between the front and the back end keeps taking
// transactions while the back end is busy until both entries are full, and
// the output register holds a finished result while the next is computed.
// Configuration may only be written while the block is idle; stores come
// up undefined and must be written before they are read.
module dense_layer_forward_sgd_unit import dlf_pkg::*; #(
  parameter int MAX_IN  = MAX_IN_DEF,
  parameter int MAX_OUT = MAX_OUT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_mode   <= ACT_MODE_RST;
      cfg_r.in_count   <= IN_COUNT_RST;
      cfg_r.out_count  <= OUT_COUNT_RST;
      cfg_r.learn_rate <= LEARN_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACT_MODE:   cfg_r.act_mode   <= cfg_data[1:0];
        CFG_IN_COUNT:   cfg_r.in_count   <= cfg_data[6:0];
        CFG_OUT_COUNT:  cfg_r.out_count  <= cfg_data[6:0];
        CFG_LEARN_RATE: cfg_r.learn_rate <= cfg_data;
      endcase
    end
  end

  // front: accept and classify, drop transactions with nothing to do
  dlf_front #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // back: stores, mac, activation and output register
  dlf_exec #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
